// File: rtl/plb_pkg.sv
// Shared types and constants for the page-mode bitmap blitter.
package plb_pkg;

   localparam int COLUMNS_PER_SIDE = 64;
   localparam int PAGE_COUNT       = 8;
   localparam int DISPLAY_WIDTH    = 2 * COLUMNS_PER_SIDE;
   localparam int COL_BITS         = $clog2(COLUMNS_PER_SIDE);
   localparam int PAGE_BITS        = $clog2(PAGE_COUNT);
   localparam int ADDR_BITS        = 1 + PAGE_BITS + COL_BITS;
   localparam int MEM_DEPTH        = 2 * PAGE_COUNT * COLUMNS_PER_SIDE;
   localparam int PREV_DEPTH       = 256;
   localparam int PREV_BITS        = $clog2(PREV_DEPTH);

   localparam logic [7:0] FULL_BYTE     = 8'hff;
   localparam logic [7:0] UNDERLINE_BIT = 8'h80;

   typedef enum logic [2:0] {
      CSR_START_COLUMN   = 3'd0,
      CSR_START_ROW      = 3'd1,
      CSR_BLIT_WIDTH     = 3'd2,
      CSR_BLIT_HEIGHT    = 3'd3,
      CSR_RASTER_OP      = 3'd4,
      CSR_INVERT_SOURCE  = 3'd5,
      CSR_UNDERLINE_LAST = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ROP_COPY    = 3'd0,
      ROP_XOR     = 3'd1,
      ROP_OR      = 3'd2,
      ROP_AND     = 3'd3,
      ROP_AND_NOT = 3'd4,
      ROP_OR_NOT  = 3'd5
   } rop_type;

   typedef struct packed {
      logic [7:0] column_byte;
      logic       first_item;
   } req_word_type;

   typedef struct packed {
      logic       side;
      logic [2:0] page;
      logic [5:0] column;
      logic [7:0] pixel_data;
      logic       status;
      logic       last;
   } rsp_word_type;

   // One display cell as seen by the cursor, handed to the merge stage
   typedef struct packed {
      logic                 live;
      logic                 err;
      logic                 write;
      logic [ADDR_BITS-1:0] addr;
      logic [PREV_BITS-1:0] prev_addr;
      logic [2:0]           off;
      logic                 first_pg;
      logic                 last_pg;
      logic                 inv;
      logic                 ul;
      logic [2:0]           op;
      logic                 last;
   } site_type;

endpackage

// File: rtl/plb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module plb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the content before a same-edge write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/plb_cursor.sv
// Configuration registers, blit parameters and page/column cursor.
module plb_cursor (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_write_data,
   input  logic             advance,
   input  logic             first_item,
   output plb_pkg::site_type site
);
   import plb_pkg::*;

   logic [6:0] start_column_ff;
   logic [5:0] start_row_ff;
   logic [7:0] blit_width_ff;
   logic [6:0] blit_height_ff;
   logic [2:0] raster_op_ff;
   logic       invert_ff;
   logic       underline_ff;

   logic [6:0] col_ff;
   logic [2:0] off_ff;
   logic [2:0] ps_ff;
   logic [4:0] pe_ff;
   logic [7:0] width_ff;
   logic [2:0] op_ff;
   logic       inv_ff;
   logic       ul_ff;
   logic       active_ff, active_in;
   logic [4:0] page_ff, page_in;
   logic [7:0] colcnt_ff, colcnt_in;

   logic       cfg_err;
   logic [4:0] cfg_pe;
   logic [6:0] e_col;
   logic [2:0] e_off;
   logic [2:0] e_ps;
   logic [4:0] e_pe;
   logic [7:0] e_width;
   logic [2:0] e_op;
   logic       e_inv;
   logic       e_ul;
   logic       e_active;
   logic [4:0] e_page;
   logic [7:0] e_cc;
   logic [8:0] x;
   logic [8:0] last_x_raw;
   logic [8:0] last_x;
   logic [4:0] last_page;
   logic [8:0] cc_next;
   logic [4:0] page_next;
   logic       on_panel;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_column_ff <= 7'd0;
         start_row_ff    <= 6'd0;
         blit_width_ff   <= 8'd8;
         blit_height_ff  <= 7'd8;
         raster_op_ff    <= 3'd0;
         invert_ff       <= 1'b0;
         underline_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_START_COLUMN:   start_column_ff <= csr_write_data[6:0];
            CSR_START_ROW:      start_row_ff    <= csr_write_data[5:0];
            CSR_BLIT_WIDTH:     blit_width_ff   <= csr_write_data;
            CSR_BLIT_HEIGHT:    blit_height_ff  <= csr_write_data[6:0];
            CSR_RASTER_OP:      raster_op_ff    <= csr_write_data[2:0];
            CSR_INVERT_SOURCE:  invert_ff       <= csr_write_data[0];
            CSR_UNDERLINE_LAST: underline_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign cfg_err = (blit_height_ff < 7'd8) || (blit_width_ff == 8'd0);
   assign cfg_pe  = 5'((9'(start_row_ff) + 9'(blit_height_ff) - 9'd1) >> 3);

   // a starting word takes its parameters straight from the registers
   always_comb begin
      if (first_item) begin
         e_col    = start_column_ff;
         e_off    = start_row_ff[2:0];
         e_ps     = start_row_ff[5:3];
         e_pe     = cfg_pe;
         e_width  = blit_width_ff;
         e_op     = raster_op_ff;
         e_inv    = invert_ff;
         e_ul     = underline_ff;
         e_active = !cfg_err;
         e_page   = {2'b00, start_row_ff[5:3]};
         e_cc     = 8'd0;
      end else begin
         e_col    = col_ff;
         e_off    = off_ff;
         e_ps     = ps_ff;
         e_pe     = pe_ff;
         e_width  = width_ff;
         e_op     = op_ff;
         e_inv    = inv_ff;
         e_ul     = ul_ff;
         e_active = active_ff;
         e_page   = page_ff;
         e_cc     = colcnt_ff;
      end
   end

   assign x          = 9'(e_col) + 9'(e_cc);
   assign on_panel   = (x < 9'(DISPLAY_WIDTH)) && (e_page < 5'(PAGE_COUNT));
   assign last_page  = (e_pe > 5'(PAGE_COUNT - 1)) ? 5'(PAGE_COUNT - 1) : e_pe;
   assign last_x_raw = 9'(e_col) + 9'(e_width) - 9'd1;
   assign last_x     = (last_x_raw > 9'(DISPLAY_WIDTH - 1)) ? 9'(DISPLAY_WIDTH - 1)
                                                            : last_x_raw;

   always_comb begin
      site.live      = e_active;
      site.err       = first_item && cfg_err;
      site.write     = e_active && on_panel;
      site.addr      = {x[COL_BITS], e_page[PAGE_BITS-1:0], x[COL_BITS-1:0]};
      site.prev_addr = e_cc;
      site.off       = e_off;
      site.first_pg  = (e_page == {2'b00, e_ps});
      site.last_pg   = (e_page == e_pe);
      site.inv       = e_inv;
      site.ul        = e_ul;
      site.op        = e_op;
      site.last      = (e_page == last_page) && (x == last_x);
   end

   // step column, wrap to the next page, stop after the last page
   always_comb begin
      cc_next   = 9'(e_cc) + 9'd1;
      page_next = e_page + 5'd1;
      active_in = e_active;
      page_in   = e_page;
      colcnt_in = cc_next[7:0];
      if (e_active && (cc_next >= 9'(e_width))) begin
         colcnt_in = 8'd0;
         page_in   = page_next;
         if (page_next > e_pe) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         page_ff   <= 5'd0;
         colcnt_ff <= 8'd0;
      end else if (advance) begin
         active_ff <= active_in;
         page_ff   <= page_in;
         colcnt_ff <= colcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && first_item) begin
         col_ff   <= e_col;
         off_ff   <= e_off;
         ps_ff    <= e_ps;
         pe_ff    <= e_pe;
         width_ff <= e_width;
         op_ff    <= e_op;
         inv_ff   <= e_inv;
         ul_ff    <= e_ul;
      end
   end

endmodule

// File: rtl/plb_merge.sv
// Source shaping, page masking and raster operation for one display byte.
module plb_merge (
   input  plb_pkg::site_type site,
   input  logic [7:0]        src_byte,
   input  logic [7:0]        prev_byte,
   input  logic [7:0]        old_byte,
   output logic [7:0]        new_byte
);
   import plb_pkg::*;

   logic [7:0]  src_b;
   logic [7:0]  src_p;
   logic [15:0] sh_b;
   logic [15:0] sh_p;
   logic [7:0]  shaped;
   logic [7:0]  mask;
   logic [7:0]  n2;
   logic [7:0]  o2;

   always_comb begin
      src_b = site.inv ? ~src_byte : src_byte;
      src_p = site.inv ? ~prev_byte : prev_byte;
      if (site.ul && site.last_pg) begin
         src_p = src_p | UNDERLINE_BIT;
      end
      sh_b = {8'h00, src_b} << site.off;
      sh_p = {8'h00, src_p} << site.off;

      if (site.off != 3'd0) begin
         // lower part of the page above, upper part of this one
         shaped = (site.first_pg ? 8'h00 : sh_p[15:8]) |
                  (site.last_pg  ? 8'h00 : sh_b[7:0]);
         if (site.last_pg) begin
            mask = FULL_BYTE << site.off;
         end else if (site.first_pg) begin
            mask = (8'h01 << site.off) - 8'h01;
         end else begin
            mask = 8'h00;
         end
      end else begin
         shaped = src_b | ((site.ul && site.last_pg) ? UNDERLINE_BIT : 8'h00);
         mask   = 8'h00;
      end

      n2 = shaped | (old_byte & mask);
      o2 = old_byte & ~mask;

      case (site.op)
         ROP_XOR:     new_byte = n2 ^ o2;
         ROP_OR:      new_byte = n2 | o2;
         ROP_AND:     new_byte = n2 & o2;
         ROP_AND_NOT: new_byte = n2 & ~o2;
         ROP_OR_NOT:  new_byte = n2 | ~o2;
         default:     new_byte = n2;
      endcase
   end

endmodule

// File: rtl/page_lcd_bitmap_blitter.sv
// Page-mode bitmap blitter top level: display RMW pipeline and output register.
// Registers: stage s1 holds an accepted request word, rsp its result word. Throughput:
// one request word per cycle while s1 is not stalled by rsp; the display memory is
// read at entry and written as the word leaves s1, with the written byte forwarded
// to a same-cell read. Reset: a clearing pass writes zero to all 1024 display bytes,
// one per cycle, with req_ready low until it ends; CSR writes are taken meanwhile.
module page_lcd_bitmap_blitter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  plb_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output plb_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_enable,
   input  logic [2:0]            csr_index,
   input  logic [7:0]            csr_write_data
);
   import plb_pkg::*;

   site_type             site;
   logic                 accept;
   logic                 enter;
   logic                 s1_adv;
   logic                 s1_valid_ff;
   site_type             s1_site_ff;
   logic [7:0]           s1_byte_ff;
   logic                 s1_fwd_ff;
   logic [7:0]           fwd_data_ff;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_word_ff;
   logic                 clear_busy_ff;
   logic [ADDR_BITS-1:0] clear_addr_ff;
   logic                 disp_we;
   logic [ADDR_BITS-1:0] disp_waddr;
   logic [7:0]           disp_wdata;
   logic [7:0]           disp_rdata;
   logic [7:0]           prev_rdata;
   logic [7:0]           old_byte;
   logic [7:0]           merged;

   plb_cursor u_cursor (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .advance          (accept),
      .first_item       (req_word.first_item),
      .site             (site)
   );

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clear_busy_ff && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;
   assign enter     = accept && (site.write || site.err);

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_busy_ff) begin
         clear_addr_ff <= clear_addr_ff + ADDR_BITS'(1);
         if (clear_addr_ff == {ADDR_BITS{1'b1}}) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   assign disp_we    = clear_busy_ff || (s1_adv && s1_site_ff.write);
   assign disp_waddr = clear_busy_ff ? clear_addr_ff : s1_site_ff.addr;
   assign disp_wdata = clear_busy_ff ? 8'h00 : merged;

   plb_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_display_ram (
      .clock   (clock),
      .wr_en   (disp_we),
      .wr_addr (disp_waddr),
      .wr_data (disp_wdata),
      .rd_en   (enter && site.write),
      .rd_addr (site.addr),
      .rd_data (disp_rdata)
   );

   // previous-page byte: read and write at the same edge, read sees the old byte
   plb_ram #(.WIDTH(8), .DEPTH(PREV_DEPTH)) u_prev_ram (
      .clock   (clock),
      .wr_en   (accept && site.live),
      .wr_addr (site.prev_addr),
      .wr_data (req_word.column_byte),
      .rd_en   (enter && site.write),
      .rd_addr (site.prev_addr),
      .rd_data (prev_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enter) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enter) begin
         s1_site_ff <= site;
         s1_byte_ff <= req_word.column_byte;
         // the read at this edge misses a write to the same cell at this edge
         s1_fwd_ff  <= s1_adv && s1_site_ff.write && (s1_site_ff.addr == site.addr);
      end
      if (s1_adv) begin
         fwd_data_ff <= merged;
      end
   end

   assign old_byte = s1_fwd_ff ? fwd_data_ff : disp_rdata;

   plb_merge u_merge (
      .site      (s1_site_ff),
      .src_byte  (s1_byte_ff),
      .prev_byte (prev_rdata),
      .old_byte  (old_byte),
      .new_byte  (merged)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         if (s1_site_ff.err) begin
            rsp_word_ff <= '{side: 1'b0, page: 3'd0, column: 6'd0,
                             pixel_data: 8'h00, status: 1'b1, last: 1'b1};
         end else begin
            rsp_word_ff <= '{side: s1_site_ff.addr[ADDR_BITS-1],
                             page: s1_site_ff.addr[COL_BITS +: PAGE_BITS],
                             column: s1_site_ff.addr[COL_BITS-1:0],
                             pixel_data: merged, status: 1'b0,
                             last: s1_site_ff.last};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_no_accept_while_clearing : assert property (
      @(posedge clock) disable iff (reset) clear_busy_ff |-> !req_ready
   ) else $error("request word taken during clearing pass");

   a_pipe_empty_while_clearing : assert property (
      @(posedge clock) disable iff (reset) clear_busy_ff |-> !s1_valid_ff && !rsp_valid_ff
   ) else $error("pipeline busy during clearing pass");

   a_error_word_shape : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status |-> rsp_word_ff.last && (rsp_word_ff.pixel_data == 8'h00)
   ) else $error("error word carries display data");

   a_fwd_follows_write : assert property (
      @(posedge clock) disable iff (reset)
      enter && s1_adv && s1_site_ff.write && site.write && (s1_site_ff.addr == site.addr)
      |=> s1_fwd_ff
   ) else $error("same-cell access not forwarded");

endmodule

// File: tb/tb_page_lcd_bitmap_blitter.sv
// Testbench for the page-mode bitmap blitter: directed table, then random blits against a predictor.
module tb_page_lcd_bitmap_blitter;
   timeunit 1ns;
   timeprecision 1ps;

   import plb_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 8;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int RANDOM_WORDS  = 450;
   localparam int ROWS_PER_PAGE = 8;

   localparam logic STATUS_WRITE       = 1'b0;
   localparam logic STATUS_PARAM_ERROR = 1'b1;

   // raster codes with no operation of their own
   localparam logic [2:0] ROP_SPARE_LOW  = 3'd6;
   localparam logic [2:0] ROP_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic [6:0] start_column;
      logic [5:0] start_row;
      logic [7:0] blit_width;
      logic [6:0] blit_height;
      logic [2:0] raster_op;
      logic       invert_source;
      logic       underline_last;
   } settings_type;

   typedef struct {
      settings_type cfg;
      logic [7:0]   column_byte;
      logic         first_item;
      bit           fixed;
      rsp_word_type want;
   } dir_row_type;

   localparam settings_type RESET_SETTINGS = '{start_column: 7'd0, start_row: 6'd0,
                                               blit_width: 8'd8, blit_height: 7'd8,
                                               raster_op: ROP_COPY, invert_source: 1'b0,
                                               underline_last: 1'b0};
   localparam rsp_word_type PARAM_ERROR_WORD = '{side: 1'b0, page: 3'd0, column: 6'd0,
                                                 pixel_data: 8'h00,
                                                 status: STATUS_PARAM_ERROR, last: 1'b1};
   localparam rsp_word_type NO_WORD = '0;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write_enable = 1'b0;
   logic [2:0]   csr_index = CSR_START_COLUMN;
   logic [7:0]   csr_write_data = 8'h00;

   // predictor state
   logic [7:0]   shadow_mem [MEM_DEPTH];
   logic [7:0]   shadow_prev [PREV_DEPTH];
   int unsigned  cur_page;
   int unsigned  cur_col;
   bit           blit_err;
   bit           blit_on;
   settings_type csr_shadow = RESET_SETTINGS;
   settings_type blit_cfg = RESET_SETTINGS;
   int unsigned  page_first;
   int unsigned  page_final;

   rsp_word_type pending_writes [$];
   dir_row_type  directed_rows [$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           words_sent = 0;
   int           random_words = 0;
   int           gap_pct = 33;
   int           rsp_idle_pct = 50;

   page_lcd_bitmap_blitter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic settings_type blit_settings(int col, int row, int width, int height,
                                                  logic [2:0] op, bit inv, bit ul);
      settings_type s;
      s.start_column   = 7'(col);
      s.start_row      = 6'(row);
      s.blit_width     = 8'(width);
      s.blit_height    = 7'(height);
      s.raster_op      = op;
      s.invert_source  = inv;
      s.underline_last = ul;
      return s;
   endfunction

   function automatic dir_row_type dir_row(settings_type cfg, logic [7:0] col_byte,
                                           logic first, bit fixed, rsp_word_type want);
      dir_row_type r;
      r.cfg         = cfg;
      r.column_byte = col_byte;
      r.first_item  = first;
      r.fixed       = fixed;
      r.want        = want;
      return r;
   endfunction

   // One cell of the blit: returns 1 when the word causes a display write or an error word.
   function automatic bit predict_write(input logic [7:0] col_byte, input logic first,
                                        output rsp_word_type w);
      int unsigned page, x, ctrl, addr, last_page, last_x;
      logic        side;
      logic [2:0]  off;
      logic [7:0]  src, newv, oldv, mask;
      bit          need_old, hit;
      w   = NO_WORD;
      hit = 1'b0;
      if (first) begin
         cur_page = 0;
         cur_col  = 0;
         if (csr_shadow.blit_height < ROWS_PER_PAGE || csr_shadow.blit_width == 8'd0) begin
            blit_err = 1'b1;
            blit_on  = 1'b0;
            w        = PARAM_ERROR_WORD;
            return 1'b1;
         end
         blit_err   = 1'b0;
         blit_on    = 1'b1;
         blit_cfg   = csr_shadow;
         page_first = blit_cfg.start_row / ROWS_PER_PAGE;
         page_final = (int'(blit_cfg.start_row) + int'(blit_cfg.blit_height) - 1)
                      / ROWS_PER_PAGE;
      end
      if (!blit_on || blit_err) return 1'b0;

      page = page_first + cur_page;
      x    = blit_cfg.start_column + cur_col;
      side = (x >= COLUMNS_PER_SIDE);
      ctrl = side ? x - COLUMNS_PER_SIDE : x;
      off  = blit_cfg.start_row[2:0];

      if (ctrl < COLUMNS_PER_SIDE && page < PAGE_COUNT) begin
         addr     = ((side ? PAGE_COUNT : 0) + page) * COLUMNS_PER_SIDE + ctrl;
         need_old = (blit_cfg.raster_op >= ROP_XOR && blit_cfg.raster_op <= ROP_OR_NOT)
                    || off != 3'd0;
         oldv     = need_old ? shadow_mem[addr] : 8'h00;

         // keep old rows above the bitmap on its first page, below it on its last
         mask = 8'h00;
         if (off != 3'd0) begin
            if (page == page_first) mask = FULL_BYTE >> (8 - off);
            if (page == page_final) mask = FULL_BYTE << off;
         end

         if (off != 3'd0) begin
            newv = 8'h00;
            if (page > page_first) begin
               src = shadow_prev[cur_col];
               if (blit_cfg.invert_source) src = ~src;
               if (blit_cfg.underline_last && page == page_final) src = src | UNDERLINE_BIT;
               newv = src >> (8 - off);
            end
            if (page < page_final) begin
               src = col_byte;
               if (blit_cfg.invert_source) src = ~src;
               newv = newv | (src << off);
            end
         end else begin
            newv = blit_cfg.invert_source ? ~col_byte : col_byte;
            if (blit_cfg.underline_last && page == page_final) newv = newv | UNDERLINE_BIT;
         end

         if (mask != 8'h00) begin
            newv = newv | (oldv & mask);
            oldv = oldv & ~mask;
         end

         if (need_old) begin
            case (blit_cfg.raster_op)
               ROP_XOR:     newv = newv ^ oldv;
               ROP_OR:      newv = newv | oldv;
               ROP_AND:     newv = newv & oldv;
               ROP_AND_NOT: newv = newv & ~oldv;
               ROP_OR_NOT:  newv = newv | ~oldv;
               default:     ;
            endcase
         end
         shadow_mem[addr] = newv;

         last_page = (page_final > PAGE_COUNT - 1) ? PAGE_COUNT - 1 : page_final;
         last_x    = blit_cfg.start_column + blit_cfg.blit_width - 1;
         if (last_x > DISPLAY_WIDTH - 1) last_x = DISPLAY_WIDTH - 1;

         w.side       = side;
         w.page       = page[2:0];
         w.column     = ctrl[5:0];
         w.pixel_data = newv;
         w.status     = STATUS_WRITE;
         w.last       = (page == last_page) && (x == last_x);
         hit          = 1'b1;
      end

      shadow_prev[cur_col] = col_byte;
      cur_col++;
      if (cur_col >= blit_cfg.blit_width) begin
         cur_col = 0;
         cur_page++;
         if (page_first + cur_page > page_final) blit_on = 1'b0;
      end
      return hit;
   endfunction

   task automatic put_csr(input logic [2:0] idx, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Hold the enable across the whole burst, drop it once at the end.
   task automatic write_settings(input settings_type s);
      put_csr(CSR_START_COLUMN,   8'(s.start_column));
      put_csr(CSR_START_ROW,      8'(s.start_row));
      put_csr(CSR_BLIT_WIDTH,     s.blit_width);
      put_csr(CSR_BLIT_HEIGHT,    8'(s.blit_height));
      put_csr(CSR_RASTER_OP,      8'(s.raster_op));
      put_csr(CSR_INVERT_SOURCE,  8'(s.invert_source));
      put_csr(CSR_UNDERLINE_LAST, 8'(s.underline_last));
      csr_write_enable <= 1'b0;
      csr_shadow = s;
   endtask

   task automatic settle();
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_word(input logic [7:0] col_byte, input logic first,
                            input bit fixed, input rsp_word_type want);
      req_word_type w;
      rsp_word_type predicted;
      bit           got;
      if (words_sent < 150) begin
         gap_pct      = 33;
         rsp_idle_pct = 50;
      end else if (words_sent < 300) begin
         gap_pct      = 50;
         rsp_idle_pct = 33;
      end else begin
         gap_pct      = 0;
         rsp_idle_pct = 0;
      end
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      w.column_byte = col_byte;
      w.first_item  = first;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      got = predict_write(col_byte, first, predicted);
      if (fixed) pending_writes.push_back(want);
      else if (got) pending_writes.push_back(predicted);
   endtask

   function automatic settings_type pick_settings();
      settings_type s;
      int unsigned  pick;
      pick = $urandom_range(19);
      s = blit_settings($urandom_range(127), $urandom_range(63), $urandom_range(1, 12),
                        $urandom_range(8, 24), 3'($urandom_range(7)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
      case (pick)
         0: begin
            if ($urandom_range(1) == 0) s.blit_height = 7'($urandom_range(7));
            else s.blit_width = 8'd0;
         end
         1: begin
            // wide bitmap on one aligned page, columns past the panel edge
            s.blit_width  = 8'($urandom_range(64, 255));
            s.blit_height = 7'(ROWS_PER_PAGE);
            s.start_row   = 6'(ROWS_PER_PAGE * $urandom_range(PAGE_COUNT - 1));
         end
         2: begin
            s.blit_width  = 8'($urandom_range(1, 3));
            s.blit_height = 7'($urandom_range(8, 127));
         end
         3: begin
            s.start_column = $urandom_range(1) ? 7'd127 : 7'd0;
            s.start_row    = $urandom_range(1) ? 6'd63 : 6'd0;
            s.blit_width   = 8'($urandom_range(1, 2));
            s.blit_height  = $urandom_range(1) ? 7'd64 : 7'd8;
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic feed_blit();
      int unsigned total;
      if (csr_shadow.blit_height < ROWS_PER_PAGE || csr_shadow.blit_width == 8'd0) begin
         total = $urandom_range(1, 3);
      end else begin
         total = csr_shadow.blit_width *
                 ((int'(csr_shadow.start_row) + int'(csr_shadow.blit_height) - 1)
                  / ROWS_PER_PAGE - csr_shadow.start_row / ROWS_PER_PAGE + 1);
      end
      // cut some blits short; the next first word restarts the counters
      if ($urandom_range(7) == 0) total = $urandom_range(1, total);
      for (int i = 0; i < total; i++) send_word(8'($urandom), i == 0, 1'b0, NO_WORD);
      random_words += total;
      if ($urandom_range(5) == 0) begin
         repeat ($urandom_range(1, 2)) send_word(8'($urandom), 1'b0, 1'b0, NO_WORD);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_writes.size() == 0) begin
            $error("result word with nothing pending: %p", rsp_word);
            error_count++;
         end else begin
            exp_w = pending_writes.pop_front();
            if (rsp_word.side != exp_w.side) begin
               $error("side: expected %0d, got %0d", exp_w.side, rsp_word.side);
               error_count++;
            end
            if (rsp_word.page != exp_w.page) begin
               $error("page: expected %0d, got %0d", exp_w.page, rsp_word.page);
               error_count++;
            end
            if (rsp_word.column != exp_w.column) begin
               $error("column: expected %0d, got %0d", exp_w.column, rsp_word.column);
               error_count++;
            end
            if (rsp_word.pixel_data != exp_w.pixel_data) begin
               $error("pixel_data: expected %h, got %h", exp_w.pixel_data, rsp_word.pixel_data);
               error_count++;
            end
            if (rsp_word.status != exp_w.status) begin
               $error("status: expected %0d, got %0d", exp_w.status, rsp_word.status);
               error_count++;
            end
            if (rsp_word.last != exp_w.last) begin
               $error("last: expected %0d, got %0d", exp_w.last, rsp_word.last);
               error_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   initial begin
      settings_type cfg;
      foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // idle word, then one cell at reset settings
      directed_rows.push_back(dir_row(RESET_SETTINGS, 8'h3C, 1'b0, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(RESET_SETTINGS, 8'hA5, 1'b1, 1'b1,
         '{side: 1'b0, page: 3'd0, column: 6'd0, pixel_data: 8'hA5,
           status: STATUS_WRITE, last: 1'b0}));
      // parameter errors; the word after one is dropped
      cfg = blit_settings(0, 0, 8, 7, ROP_COPY, 1'b0, 1'b0);
      directed_rows.push_back(dir_row(cfg, 8'h00, 1'b1, 1'b1, PARAM_ERROR_WORD));
      directed_rows.push_back(dir_row(cfg, 8'hFF, 1'b0, 1'b0, NO_WORD));
      cfg = blit_settings(0, 0, 0, 8, ROP_COPY, 1'b0, 1'b0);
      directed_rows.push_back(dir_row(cfg, 8'h5A, 1'b1, 1'b1, PARAM_ERROR_WORD));
      cfg = blit_settings(0, 0, 8, 0, ROP_COPY, 1'b0, 1'b0);
      directed_rows.push_back(dir_row(cfg, 8'hC3, 1'b1, 1'b1, PARAM_ERROR_WORD));
      // bottom right corner cell
      cfg = blit_settings(127, 56, 1, 8, ROP_COPY, 1'b0, 1'b0);
      directed_rows.push_back(dir_row(cfg, 8'hFF, 1'b1, 1'b1,
         '{side: 1'b1, page: 3'd7, column: 6'd63, pixel_data: 8'hFF,
           status: STATUS_WRITE, last: 1'b1}));
      // lowest start row: second page falls below the panel
      cfg = blit_settings(0, 63, 1, 8, ROP_XOR, 1'b0, 1'b0);
      directed_rows.push_back(dir_row(cfg, 8'h81, 1'b1, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(cfg, 8'h42, 1'b0, 1'b0, NO_WORD));
      // shifted, inverted, underlined, across the controller boundary
      cfg = blit_settings(63, 3, 2, 16, ROP_OR, 1'b1, 1'b1);
      directed_rows.push_back(dir_row(cfg, 8'hF0, 1'b1, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(cfg, 8'h0F, 1'b0, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(cfg, 8'hAA, 1'b0, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(cfg, 8'h55, 1'b0, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(cfg, 8'h00, 1'b0, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(cfg, 8'hFF, 1'b0, 1'b0, NO_WORD));
      // remaining raster operations and the spare codes
      directed_rows.push_back(dir_row(blit_settings(64, 0, 1, 8, ROP_AND, 1'b0, 1'b0),
                                      8'hE7, 1'b1, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(blit_settings(64, 0, 1, 8, ROP_AND_NOT, 1'b0, 1'b0),
                                      8'h3C, 1'b1, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(blit_settings(64, 0, 1, 8, ROP_OR_NOT, 1'b0, 1'b0),
                                      8'h96, 1'b1, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(blit_settings(64, 0, 1, 8, ROP_SPARE_LOW, 1'b0, 1'b0),
                                      8'h5A, 1'b1, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(blit_settings(64, 0, 1, 8, ROP_SPARE_HIGH, 1'b0, 1'b0),
                                      8'hA5, 1'b1, 1'b0, NO_WORD));
      // columns past the right edge give no write
      cfg = blit_settings(126, 8, 4, 8, ROP_COPY, 1'b0, 1'b1);
      directed_rows.push_back(dir_row(cfg, 8'h11, 1'b1, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(cfg, 8'h22, 1'b0, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(cfg, 8'h33, 1'b0, 1'b0, NO_WORD));
      directed_rows.push_back(dir_row(cfg, 8'h44, 1'b0, 1'b0, NO_WORD));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].first_item && directed_rows[i].cfg != csr_shadow) begin
            req_valid <= 1'b0;
            settle();
            write_settings(directed_rows[i].cfg);
         end
         send_word(directed_rows[i].column_byte, directed_rows[i].first_item,
                   directed_rows[i].fixed, directed_rows[i].want);
      end

      while (random_words < RANDOM_WORDS) begin
         req_valid <= 1'b0;
         settle();
         write_settings(pick_settings());
         repeat ($urandom_range(1, 3)) feed_blit();
      end

      req_valid <= 1'b0;
      settle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
